/* sv/bbcw_pkg.sv */
`timescale 1ns / 1ps
// Package for the box blur block: image limits, field widths and register indexes.
// It depends on nothing. bbcw_ifs and box_blur_clipped_window use it.
package bbcw_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_SQUARE = 15;

	localparam int X_W    = 6;
	localparam int Y_W    = 6;
	localparam int DIM_W  = 7;
	localparam int SIZE_W = 4;
	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int CNT_W  = $clog2(MAX_SQUARE * MAX_SQUARE + 1);
	localparam int SUM_W  = $clog2(MAX_SQUARE * MAX_SQUARE * 255
		+ (MAX_SQUARE * MAX_SQUARE) / 2 + 1);
	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE_SIZE  = 2'd2;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_BLUR  = 1'b1;

	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 7'd64;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 7'd64;
	localparam logic [SIZE_W-1:0] RST_SQUARE_SIZE  = 4'd3;

endpackage

/* sv/bbcw_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the box blur block: request, result and configuration.
// They depend on bbcw_pkg for field widths.
interface bbcw_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [bbcw_pkg::X_W-1:0]     pos_x;
	logic [bbcw_pkg::Y_W-1:0]     pos_y;
	logic [bbcw_pkg::CHAN_W-1:0]  in_red;
	logic [bbcw_pkg::CHAN_W-1:0]  in_green;
	logic [bbcw_pkg::CHAN_W-1:0]  in_blue;

	modport source (output valid, operation, pos_x, pos_y, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, operation, pos_x, pos_y, in_red, in_green, in_blue,
		output ready);
endinterface

interface bbcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bbcw_pkg::CHAN_W-1:0]  out_red;
	logic [bbcw_pkg::CHAN_W-1:0]  out_green;
	logic [bbcw_pkg::CHAN_W-1:0]  out_blue;
	logic                         out_of_range;

	modport source (output valid, out_red, out_green, out_blue, out_of_range, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_of_range, output ready);
endinterface

interface bbcw_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bbcw_pkg::CFG_IDX_W-1:0]   index;
	logic [bbcw_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/bbcw_ram.sv */
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// It depends on nothing; width and depth are parameters.
module bbcw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* sv/box_blur_clipped_window.sv */
`timescale 1ns / 1ps
// Box blur over a stored RGB image; uses bbcw_pkg, bbcw_ifs and bbcw_ram.
// Holds the pixel store, the configuration registers and the blur sequencer.
//
// A store request writes one pixel into a 4096 x 24 single-port RAM if it lies in the image.
// A blur request clips its window to the image, then reads the window one pixel per
// cycle from that RAM port and accumulates three channel sums; three shift-subtract
// dividers then produce the rounded means one quotient bit per cycle. The window holds
// 1 to 225 pixels, and the divider takes 16 steps. A blur outside the image skips the scan
// and the division and answers with zero channels and out_of_range set. The result sits in an
// output register, so a new request is taken while it waits.
// The pixel store has no reset; blur only pixels that have been written.
module box_blur_clipped_window (
	input  logic          clk,
	input  logic          arst_n,
	bbcw_req_if.sink      req,
	bbcw_rsp_if.source    rsp,
	bbcw_cfg_if.sink      cfg
);

	typedef enum logic [2:0] {IDLE, SCAN, DRAIN, PREP, DIV, DONE} state_t;

	localparam int DIM_W  = bbcw_pkg::DIM_W;
	localparam int SUM_W  = bbcw_pkg::SUM_W;
	localparam int CNT_W  = bbcw_pkg::CNT_W;
	localparam int CHAN_W = bbcw_pkg::CHAN_W;

	state_t state_q;

	logic [DIM_W-1:0]            image_width_q;
	logic [DIM_W-1:0]            image_height_q;
	logic [bbcw_pkg::SIZE_W-1:0] square_size_q;

	logic [bbcw_pkg::X_W-1:0] left_q, col_q;
	logic [bbcw_pkg::Y_W-1:0] top_q, row_q;
	logic [DIM_W-1:0]         right_q, bottom_q;
	logic                     rd_pend_s1;

	logic [SUM_W-1:0]            sum_q [3];
	logic [SUM_W-1:0]            dvd_q [3];
	logic [CNT_W-1:0]            rem_q [3];
	logic [SUM_W-1:0]            dvd_nxt [3];
	logic [CNT_W-1:0]            rem_nxt [3];
	logic [CNT_W-1:0]            count_q;
	logic [bbcw_pkg::STEP_W-1:0] step_q;
	logic                        oor_q;

	logic              rsp_valid_q, oor_out_q;
	logic [CHAN_W-1:0] red_q, green_q, blue_q;

	logic [DIM_W-1:0]              w_eff, h_eff, right_c, bottom_c;
	logic [bbcw_pkg::SIZE_W-1:0]   s_eff;
	logic [bbcw_pkg::SIZE_W-2:0]   half;
	logic                          par, in_image, req_accept;
	logic [bbcw_pkg::X_W-1:0]      left_c;
	logic [bbcw_pkg::Y_W-1:0]      top_c;
	logic                          col_last, row_last;

	logic                          ram_we, ram_re;
	logic [bbcw_pkg::ADDR_W-1:0]   ram_addr;
	logic [bbcw_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;

	assign cfg.ready  = 1'b1;
	assign req.ready  = (state_q == IDLE);
	assign req_accept = req.valid && req.ready;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_red      = red_q;
	assign rsp.out_green    = green_q;
	assign rsp.out_blue     = blue_q;
	assign rsp.out_of_range = oor_out_q;

	always_comb begin
		w_eff = (image_width_q > DIM_W'(bbcw_pkg::MAX_WIDTH)) ?
			DIM_W'(bbcw_pkg::MAX_WIDTH) : image_width_q;
		h_eff = (image_height_q > DIM_W'(bbcw_pkg::MAX_HEIGHT)) ?
			DIM_W'(bbcw_pkg::MAX_HEIGHT) : image_height_q;
		s_eff = (square_size_q == '0) ? bbcw_pkg::SIZE_W'(1) : square_size_q;
		if (s_eff > bbcw_pkg::SIZE_W'(bbcw_pkg::MAX_SQUARE)) begin
			s_eff = bbcw_pkg::SIZE_W'(bbcw_pkg::MAX_SQUARE);
		end
		half     = s_eff[bbcw_pkg::SIZE_W-1:1];
		par      = s_eff[0];
		in_image = (DIM_W'(req.pos_x) < w_eff) && (DIM_W'(req.pos_y) < h_eff);
		left_c = (req.pos_x >= bbcw_pkg::X_W'(half)) ?
			req.pos_x - bbcw_pkg::X_W'(half) : '0;
		top_c  = (req.pos_y >= bbcw_pkg::Y_W'(half)) ?
			req.pos_y - bbcw_pkg::Y_W'(half) : '0;
		right_c  = DIM_W'(req.pos_x) + DIM_W'(half) + DIM_W'(par);
		bottom_c = DIM_W'(req.pos_y) + DIM_W'(half) + DIM_W'(par);
		if (right_c > w_eff) begin
			right_c = w_eff;
		end
		if (bottom_c > h_eff) begin
			bottom_c = h_eff;
		end
	end

	assign col_last = (DIM_W'(col_q) + DIM_W'(1)) == right_q;
	assign row_last = (DIM_W'(row_q) + DIM_W'(1)) == bottom_q;

	always_comb begin
		ram_we    = req_accept && (req.operation == bbcw_pkg::OP_STORE) && in_image;
		ram_re    = (state_q == SCAN);
		ram_wdata = {req.in_red, req.in_green, req.in_blue};
		if (state_q == SCAN) begin
			ram_addr = bbcw_pkg::ADDR_W'(row_q) * bbcw_pkg::ADDR_W'(bbcw_pkg::MAX_WIDTH)
				+ bbcw_pkg::ADDR_W'(col_q);
		end else begin
			ram_addr = bbcw_pkg::ADDR_W'(req.pos_y)
				* bbcw_pkg::ADDR_W'(bbcw_pkg::MAX_WIDTH) + bbcw_pkg::ADDR_W'(req.pos_x);
		end
	end

	bbcw_ram #(
		.WIDTH(bbcw_pkg::PIX_W),
		.DEPTH(bbcw_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// One restoring division step per channel: the partial remainder stays below the count.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [CNT_W:0] trial;
			trial = {rem_q[ch], dvd_q[ch][SUM_W-1]};
			if (trial >= {1'b0, count_q}) begin
				rem_nxt[ch] = CNT_W'(trial - {1'b0, count_q});
				dvd_nxt[ch] = {dvd_q[ch][SUM_W-2:0], 1'b1};
			end else begin
				rem_nxt[ch] = trial[CNT_W-1:0];
				dvd_nxt[ch] = {dvd_q[ch][SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			image_width_q  <= bbcw_pkg::RST_IMAGE_WIDTH;
			image_height_q <= bbcw_pkg::RST_IMAGE_HEIGHT;
			square_size_q  <= bbcw_pkg::RST_SQUARE_SIZE;
			rd_pend_s1     <= 1'b0;
			rsp_valid_q    <= 1'b0;
			count_q        <= '0;
			step_q         <= '0;
			oor_q          <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bbcw_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
					bbcw_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
					bbcw_pkg::REG_SQUARE_SIZE:  square_size_q  <= cfg.data[bbcw_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end

			if (rsp.valid && rsp.ready && (state_q != DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			rd_pend_s1 <= (state_q == SCAN);
			if (rd_pend_s1) begin
				sum_q[0] <= sum_q[0] + SUM_W'(ram_rdata[3*CHAN_W-1:2*CHAN_W]);
				sum_q[1] <= sum_q[1] + SUM_W'(ram_rdata[2*CHAN_W-1:CHAN_W]);
				sum_q[2] <= sum_q[2] + SUM_W'(ram_rdata[CHAN_W-1:0]);
				count_q  <= count_q + CNT_W'(1);
			end

			case (state_q)
				IDLE: begin
					if (req_accept && (req.operation == bbcw_pkg::OP_BLUR)) begin
						if (in_image) begin
							left_q   <= left_c;
							col_q    <= left_c;
							top_q    <= top_c;
							row_q    <= top_c;
							right_q  <= right_c;
							bottom_q <= bottom_c;
							for (int ch = 0; ch < 3; ch++) begin
								sum_q[ch] <= '0;
							end
							count_q <= '0;
							oor_q   <= 1'b0;
							state_q <= SCAN;
						end else begin
							for (int ch = 0; ch < 3; ch++) begin
								dvd_q[ch] <= '0;
							end
							oor_q   <= 1'b1;
							state_q <= DONE;
						end
					end
				end
				SCAN: begin
					if (col_last) begin
						col_q <= left_q;
						if (row_last) begin
							state_q <= DRAIN;
						end else begin
							row_q <= row_q + bbcw_pkg::Y_W'(1);
						end
					end else begin
						col_q <= col_q + bbcw_pkg::X_W'(1);
					end
				end
				DRAIN: begin
					state_q <= PREP;
				end
				PREP: begin
					for (int ch = 0; ch < 3; ch++) begin
						dvd_q[ch] <= sum_q[ch] + SUM_W'(count_q >> 1);
						rem_q[ch] <= '0;
					end
					step_q  <= '0;
					state_q <= DIV;
				end
				DIV: begin
					for (int ch = 0; ch < 3; ch++) begin
						dvd_q[ch] <= dvd_nxt[ch];
						rem_q[ch] <= rem_nxt[ch];
					end
					step_q <= step_q + bbcw_pkg::STEP_W'(1);
					if (step_q == bbcw_pkg::STEP_W'(SUM_W - 1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						red_q       <= dvd_q[0][CHAN_W-1:0];
						green_q     <= dvd_q[1][CHAN_W-1:0];
						blue_q      <= dvd_q[2][CHAN_W-1:0];
						oor_out_q   <= oor_q;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) |-> (col_q >= left_q) && (DIM_W'(col_q) < right_q)
			&& (row_q >= top_q) && (DIM_W'(row_q) < bottom_q))
		else $error("scan coordinate left the clipped window");

	a_read_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == SCAN))
		else $error("read data accumulated without a scan read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(bbcw_pkg::MAX_SQUARE * bbcw_pkg::MAX_SQUARE))
		else $error("window pixel count exceeds the largest window");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DONE && oor_q) |-> (dvd_q[0] == '0) && (dvd_q[1] == '0)
			&& (dvd_q[2] == '0))
		else $error("out-of-range result carries nonzero channels");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == DONE))
		else $error("result raised outside the done state");

endmodule
